// ===== src/assert_macros.svh =====
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ===== src/eppc_pkg.sv =====
package eppc_pkg;
	localparam int MaxLen   = 1024;
	localparam int Alphabet = 26;
	localparam int Nodes    = MaxLen + 2;
	localparam int NW       = 11;
	localparam int PW       = 11;
	localparam int LW       = 12;
	localparam int CW       = 30;
	localparam int ChildN   = Nodes * Alphabet;
	localparam int ChW      = 15;
	localparam logic [CW-1:0] Modulus = 30'd1000000007;
	localparam logic [4:0] Sentinel = 5'd26;

	typedef struct packed {
		logic [4:0] symbol;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [CW-1:0] partition_count;
		logic [PW-1:0] prefix_length;
		logic          overflow;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_FIT_RD, ST_FIT_TXT, ST_FIT_CMP, ST_CH_RD, ST_CH_CHK,
		ST_F_RD, ST_F_NODE, ST_NEW_WR,
		ST_WALK_RD, ST_WALK_RD2, ST_WALK_CALC, ST_WALK_ACC, ST_DONE, ST_OUT
	} state_t;
endpackage

// ===== src/even_palindrome_partition_counter_core.sv =====
// Even-length palindrome partition counter. One letter per input transaction; one result per
// transaction (count mod 1000000007, prefix length, overflow). Each item runs a fit search
// along suffix links (one step at least), then a walk along series links; when a new node is
// made, a second fit search finds its suffix link and the node is written before the walk. A
// letter past capacity skips both and returns the stored count of the full prefix. The cost is
// set by the node memories, whose reads are registered. The result register holds one result,
// so the next letter is taken while it waits. After reset and after every item marked last, a
// clearing pass sweeps all 26676 entries of the child table (node stores are swept alongside);
// no input is taken during it.
module even_palindrome_partition_counter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  eppc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output eppc_pkg::out_item_t out_data
);
	import eppc_pkg::*;

	logic [4:0] text_mem [0:MaxLen];
	logic [NW-1:0] child_mem [0:ChildN-1];
	logic [NW-1:0] slink_mem [0:Nodes-1];
	logic [NW-1:0] ser_mem [0:Nodes-1];
	logic [LW-1:0] len_mem [0:Nodes-1];
	logic [NW-1:0] gap_mem [0:Nodes-1];
	logic [CW-1:0] sum_mem [0:Nodes-1];
	logic [CW-1:0] pc_mem [0:MaxLen];

	state_t state_q, state_d;
	logic [ChW-1:0] clr_q;
	logic [4:0] c_q;
	logic last_q, ovf_q, fit2_q;
	logic [PW-1:0] pos_q, i_q;
	logic [NW-1:0] cur_q, ntot_q, n_q, u_q, x_q, f_q;
	logic [LW-1:0] lu_q;
	logic [CW-1:0] acc_q, cnt_q;
	logic [NW+1:0] guard_q;
	// registered memory reads
	logic [4:0] txt_rd_q;
	logic kvalid_q, kw_ok_q;
	logic [NW-1:0] ch_rd_q, sl_rd_q, ser_rd_q, gap_rd_q, fgap_q;
	logic [LW-1:0] len_rd_q;
	logic [CW-1:0] sum_rd_q, pc_rd_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [4:0] csym, txt_k;
	logic fit_ok, fit_end, ch_new, walk_go, out_load;
	logic signed [LW+1:0] kfit, kwalk;
	logic kfit_ok, kwalk_ok;
	logic [NW-1:0] ch_node;
	logic [ChW-1:0] ch_addr;
	logic [LW-1:0] lnew;
	logic [NW-1:0] gnew;
	logic [CW:0] gsum, accw;
	logic [CW-1:0] gbase, gval, accsum;

	assign csym = (in_data.symbol >= 5'(Alphabet)) ? in_data.symbol - 5'(Alphabet)
		: in_data.symbol;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// text index k = i - len - 1 for the fit search
	assign kfit = $signed({3'b0, i_q}) - $signed({{2{len_rd_q[LW-1]}}, len_rd_q}) - 14'sd1;
	assign kfit_ok = !kfit[LW+1] && (kfit <= (LW+2)'(MaxLen));
	assign txt_k = kvalid_q ? txt_rd_q : Sentinel;
	assign fit_ok = (txt_k == c_q);
	assign fit_end = fit_ok || (guard_q > (NW+2)'(MaxLen + 2));

	assign ch_node = (state_q == ST_F_RD) ? n_q : u_q;
	assign ch_addr = ChW'(ch_node) * ChW'(Alphabet) + ChW'(c_q);
	assign ch_new = (ch_rd_q == '0) && (ntot_q < NW'(Nodes));

	// new node fields, len_rd_q and gap_rd_q hold the suffix-link target here
	assign lnew = lu_q + LW'(2);
	assign gnew = NW'(lnew - len_rd_q);

	// prefix index i - gap(x) - len(series link of x) for the walk
	assign kwalk = $signed({3'b0, i_q}) - $signed({3'b0, gap_rd_q}) -
		$signed({{2{len_rd_q[LW-1]}}, len_rd_q});
	assign kwalk_ok = !kwalk[LW+1] && (kwalk <= (LW+2)'(MaxLen));
	assign walk_go = (x_q > NW'(1)) && (x_q < NW'(Nodes)) &&
		(guard_q <= (NW+2)'(MaxLen + 2));

	assign gbase = kw_ok_q ? pc_rd_q : '0;
	assign gsum = {1'b0, gbase} + {1'b0, sum_rd_q};
	assign gval = (gap_rd_q == fgap_q) ? ((gsum >= {1'b0, Modulus}) ?
		CW'(gsum - {1'b0, Modulus}) : gsum[CW-1:0]) : gbase;
	assign accw = {1'b0, acc_q} + {1'b0, gval};
	assign accsum = (accw >= {1'b0, Modulus}) ? CW'(accw - {1'b0, Modulus}) : accw[CW-1:0];

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == ChW'(ChildN - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = (pos_q >= PW'(MaxLen)) ? ST_DONE : ST_FIT_RD;
			ST_FIT_RD: state_d = ST_FIT_TXT;
			ST_FIT_TXT: state_d = ST_FIT_CMP;
			ST_FIT_CMP: begin
				if (!fit_end) state_d = ST_FIT_RD;
				else if (fit2_q) state_d = ST_F_RD;
				else state_d = ST_CH_RD;
			end
			ST_CH_RD: state_d = ST_CH_CHK;
			ST_CH_CHK: state_d = ch_new ? ST_FIT_RD : ST_WALK_RD;
			ST_F_RD: state_d = ST_F_NODE;
			ST_F_NODE: state_d = ST_NEW_WR;
			ST_NEW_WR: state_d = ST_WALK_RD;
			ST_WALK_RD: state_d = walk_go ? ST_WALK_RD2 : ST_DONE;
			ST_WALK_RD2: state_d = ST_WALK_CALC;
			ST_WALK_CALC: state_d = ST_WALK_ACC;
			ST_WALK_ACC: state_d = ST_WALK_RD;
			ST_DONE: state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = last_q ? ST_CLEAR : ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory block
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CLEAR: begin
				child_mem[clr_q] <= '0;
				if (clr_q < ChW'(Nodes)) begin
					slink_mem[clr_q[NW-1:0]] <= (clr_q == '0) ? NW'(1) : '0;
					ser_mem[clr_q[NW-1:0]] <= '0;
					len_mem[clr_q[NW-1:0]] <= (clr_q == ChW'(1)) ? '1 : '0;
					gap_mem[clr_q[NW-1:0]] <= '0;
					sum_mem[clr_q[NW-1:0]] <= '0;
				end
				if (clr_q <= ChW'(MaxLen)) begin
					text_mem[clr_q[PW-1:0]] <= (clr_q == '0) ? Sentinel : '0;
					pc_mem[clr_q[PW-1:0]] <= (clr_q == '0) ? CW'(1) : '0;
				end
			end
			ST_IDLE: if (in_valid && pos_q < PW'(MaxLen))
				text_mem[pos_q + PW'(1)] <= csym;
			ST_FIT_RD: begin
				len_rd_q <= len_mem[n_q];
				sl_rd_q <= slink_mem[n_q];
			end
			ST_FIT_TXT: begin
				kvalid_q <= kfit_ok;
				if (kfit_ok) txt_rd_q <= text_mem[kfit[PW-1:0]];
			end
			ST_CH_RD, ST_F_RD: ch_rd_q <= child_mem[ch_addr];
			ST_F_NODE: begin
				len_rd_q <= len_mem[ch_rd_q];
				gap_rd_q <= gap_mem[ch_rd_q];
				ser_rd_q <= ser_mem[ch_rd_q];
			end
			ST_NEW_WR: begin
				child_mem[ch_addr] <= ntot_q;
				slink_mem[ntot_q] <= f_q;
				len_mem[ntot_q] <= lnew;
				gap_mem[ntot_q] <= gnew;
				ser_mem[ntot_q] <= (gnew == gap_rd_q) ? ser_rd_q : f_q;
			end
			ST_WALK_RD: if (walk_go) begin
				gap_rd_q <= gap_mem[x_q];
				ser_rd_q <= ser_mem[x_q];
				sl_rd_q <= slink_mem[x_q];
			end
			ST_WALK_RD2: begin
				len_rd_q <= len_mem[ser_rd_q];
				fgap_q <= gap_mem[sl_rd_q];
				sum_rd_q <= sum_mem[sl_rd_q];
			end
			ST_WALK_CALC: begin
				kw_ok_q <= kwalk_ok;
				if (kwalk_ok) pc_rd_q <= pc_mem[kwalk[PW-1:0]];
			end
			ST_WALK_ACC: sum_mem[x_q] <= gval;
			ST_DONE: begin
				if (ovf_q) pc_rd_q <= pc_mem[PW'(MaxLen)];
				else pc_mem[i_q] <= i_q[0] ? '0 : acc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pos_q <= '0;
			cur_q <= NW'(1);
			ntot_q <= NW'(2);
			out_valid_q <= 1'b0;
			out_q <= '0;
			guard_q <= '0;
			c_q <= '0;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
			fit2_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			u_q <= '0;
			x_q <= '0;
			f_q <= '0;
			lu_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= (clr_q == ChW'(ChildN - 1)) ? '0 : clr_q + ChW'(1);
					pos_q <= '0;
					cur_q <= NW'(1);
					ntot_q <= NW'(2);
				end
				ST_IDLE: if (in_valid) begin
					c_q <= csym;
					last_q <= in_data.last;
					ovf_q <= pos_q >= PW'(MaxLen);
					i_q <= pos_q + PW'(1);
					n_q <= cur_q;
					fit2_q <= 1'b0;
					guard_q <= '0;
					acc_q <= '0;
				end
				ST_FIT_CMP: begin
					if (!fit_end) begin
						n_q <= sl_rd_q;
						guard_q <= guard_q + (NW+2)'(1);
					end else begin
						guard_q <= '0;
						if (!fit2_q) begin
							u_q <= n_q;
							lu_q <= len_rd_q;
						end
					end
				end
				// sl_rd_q still holds the suffix link of u from the last fit read
				ST_CH_CHK: begin
					if (ch_new) begin
						n_q <= sl_rd_q;
						fit2_q <= 1'b1;
					end else begin
						x_q <= ch_rd_q;
						cur_q <= ch_rd_q;
					end
				end
				ST_F_NODE: f_q <= ch_rd_q;
				ST_NEW_WR: begin
					ntot_q <= ntot_q + NW'(1);
					x_q <= ntot_q;
					cur_q <= ntot_q;
				end
				ST_WALK_ACC: begin
					acc_q <= accsum;
					x_q <= ser_rd_q;
					guard_q <= guard_q + (NW+2)'(1);
				end
				ST_DONE: if (!ovf_q) begin
					cnt_q <= i_q[0] ? '0 : acc_q;
					pos_q <= i_q;
				end
				ST_OUT: if (out_load) begin
					out_q.partition_count <= ovf_q ? pc_rd_q : cnt_q;
					out_q.prefix_length <= ovf_q ? PW'(MaxLen) : i_q;
					out_q.overflow <= ovf_q;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== src/eppc_checker.sv =====
module eppc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input eppc_pkg::out_item_t out_data
);
	import eppc_pkg::*;
`include "assert_macros.svh"
	`CHK_NEXT(out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHK_NEXT(busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	`CHK_IMPLY(len_range, clk, arst_n, out_valid,
		out_data.prefix_length != '0 && out_data.partition_count < Modulus)
	`CHK_IMPLY(odd_zero, clk, arst_n, out_valid && !out_data.overflow &&
		out_data.prefix_length[0], out_data.partition_count == '0)
endmodule

bind even_palindrome_partition_counter_core eppc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== bench/tb_even_palindrome_partition_counter_core.sv =====
module tb_even_palindrome_partition_counter_core;
	import eppc_pkg::*;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int TAIL_CYCLES = 200;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	even_palindrome_partition_counter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// shadow copy of the palindromic tree
	logic [4:0]  txt [0:MaxLen];
	int          kid [0:ChildN-1];
	int          slink [0:Nodes-1];
	int          serl [0:Nodes-1];
	int          nlen [0:Nodes-1];
	int          lgap [0:Nodes-1];
	int unsigned ssum [0:Nodes-1];
	int unsigned pcnt [0:MaxLen];
	int          ntot;
	int          cur;
	int          pos;

	out_item_t count_queue [$];
	int        mismatches;
	int        cycles;

	function automatic void tree_clear();
		for (int n = 0; n < ChildN; n++) kid[n] = 0;
		for (int n = 0; n < Nodes; n++) begin
			slink[n] = 0;
			serl[n] = 0;
			nlen[n] = 0;
			lgap[n] = 0;
			ssum[n] = 0;
		end
		for (int n = 0; n <= MaxLen; n++) begin
			txt[n] = 5'd0;
			pcnt[n] = 0;
		end
		txt[0] = Sentinel;
		slink[0] = 1;
		nlen[1] = -1;
		pcnt[0] = 1;
		ntot = 2;
		cur = 1;
		pos = 0;
	endfunction

	function automatic int unsigned add_mod(int unsigned a, int unsigned b);
		int unsigned s;
		s = a + b;
		return (s >= Modulus) ? s - Modulus : s;
	endfunction

	function automatic logic [4:0] letter_ahead(int i, int len);
		int k;
		k = i - len - 1;
		if (k < 0 || k > MaxLen) return Sentinel;
		return txt[k];
	endfunction

	function automatic int fit_node(int node, int i, logic [4:0] c);
		int guard;
		guard = 0;
		while (letter_ahead(i, nlen[node]) != c && guard <= MaxLen + 2) begin
			node = slink[node];
			guard++;
		end
		return node;
	endfunction

	function automatic out_item_t count_partitions(in_item_t item);
		out_item_t   res;
		logic [4:0]  c;
		int          i, u, v, f, nv, x, k, walk;
		int unsigned acc, g;
		c = 5'(int'(item.symbol) % Alphabet);
		res.overflow = 1'b0;
		if (pos >= MaxLen) begin
			res.overflow = 1'b1;
			res.partition_count = pcnt[MaxLen];
			res.prefix_length = PW'(MaxLen);
		end else begin
			i = pos + 1;
			acc = 0;
			walk = 0;
			txt[i] = c;
			u = fit_node(cur, i, c);
			if (kid[u * Alphabet + c] == 0 && ntot < Nodes) begin
				nv = ntot;
				v = fit_node(slink[u], i, c);
				f = kid[v * Alphabet + c];
				slink[nv] = f;
				kid[u * Alphabet + c] = nv;
				nlen[nv] = nlen[u] + 2;
				lgap[nv] = nlen[nv] - nlen[f];
				serl[nv] = (lgap[nv] == lgap[f]) ? serl[f] : f;
				ntot++;
			end
			cur = kid[u * Alphabet + c];
			x = cur;
			while (x > 1 && x < Nodes && walk <= MaxLen + 2) begin
				k = i - lgap[x] - nlen[serl[x]];
				f = slink[x];
				g = (k >= 0 && k <= MaxLen) ? pcnt[k] : 0;
				if (lgap[x] == lgap[f]) g = add_mod(g, ssum[f]);
				ssum[x] = g;
				acc = add_mod(acc, g);
				walk++;
				x = serl[x];
			end
			if (i % 2 == 1) acc = 0;
			pcnt[i] = acc;
			pos = i;
			res.partition_count = CW'(acc);
			res.prefix_length = PW'(i);
		end
		if (item.last) tree_clear();
		return res;
	endfunction

	// in_valid stays high between back-to-back transactions
	task automatic send_letter(logic [4:0] sym, logic last);
		int gap;
		in_item_t item;
		gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		item.symbol = sym;
		item.last = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		count_queue.push_back(count_partitions(item));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (count_queue.size() > 0) @(posedge clk);
	endtask

	task automatic test_even_odd();
		send_letter(5'd0, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd1, 1'b0);
		send_letter(5'd1, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd0, 1'b1);
	endtask

	task automatic test_letter_extremes();
		send_letter(5'd25, 1'b1);
		send_letter(5'd26, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd31, 1'b0);
		send_letter(5'd5, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(5'd25, 1'b1);
	endtask

	task automatic test_overflow();
		drain_results();
		for (int n = 0; n < MaxLen; n++)
			send_letter(5'($urandom_range(0, 1)), 1'b0);
		send_letter(5'd3, 1'b0);
		send_letter(5'd30, 1'b0);
		send_letter(5'd0, 1'b1);
		send_letter(5'd0, 1'b0);
		send_letter(5'd0, 1'b1);
	endtask

	task automatic test_random_strings();
		int len, span;
		logic [4:0] sym;
		for (int s = 0; s < 24; s++) begin
			len = $urandom_range(1, 80);
			span = $urandom_range(0, 4);
			for (int n = 0; n < len; n++) begin
				if (span == 4) sym = 5'($urandom_range(0, 31));
				else sym = 5'($urandom_range(0, span));
				send_letter(sym, n == len - 1);
			end
			if (s == 9) drain_results();
		end
	endtask

	// result side with random stalls
	initial begin
		int stall;
		out_item_t got, want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			got = out_data;
			@(posedge clk);
			if (count_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %p", got);
			end else begin
				want = count_queue.pop_front();
				if (got.partition_count !== want.partition_count ||
					got.prefix_length !== want.prefix_length ||
					got.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		tree_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_even_odd();
		test_letter_extremes();
		test_random_strings();
		test_overflow();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && count_queue.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/eppc_pkg.sv
src/even_palindrome_partition_counter_core.sv
src/eppc_checker.sv
bench/tb_even_palindrome_partition_counter_core.sv
